/* src/assert_macros.svh */
// Assertion macros shared by the formatter RTL.
// Stands alone; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sdrf_pkg.sv */
// Types and constants for the signed decimal report formatter.
// No dependencies.
package sdrf_pkg;

    // Port widths fixed by the item formats.
    localparam int unsigned IN_W   = 32;
    localparam int unsigned CHAR_W = 8;

    // Characters of the report text.
    localparam logic [CHAR_W-1:0] CHAR_R     = 8'h52;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    // Double-dabble correction: a BCD digit of five or more gets three added.
    localparam logic [3:0] BCD_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ   = 4'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_TRIM,
        S_EMIT_R,
        S_EMIT_SP,
        S_EMIT_MINUS,
        S_EMIT_DIG
    } t_state;

endpackage

/* src/signed_decimal_report_formatter.sv */
// Top level of the signed decimal report formatter: reading in, ASCII text out.
// Depends on sdrf_pkg and assert_macros.svh.
//
// Usage:
//   Slave stream: one item per reading, tdata carries the signed reading.
//   Master stream: one item per character, tdata carries the ASCII code and
//   tlast marks the final character. A report reads "R ", an optional '-',
//   then the decimal magnitude without leading zeros ("R 0" for zero).
//   The most negative reading keeps its full magnitude.
//   One reading is handled at a time; tready on the slave side is high only
//   while the block is idle. A reading is converted by a bit-serial
//   shift-and-add-three unit, one bit per cycle until all VALUE_BITS bits are in, then
//   leading zero digits are dropped one per cycle, then one character leaves
//   per cycle while the receiver takes each one. The next reading is taken
//   only after the final character of the report has been loaded into the
//   output register.
//   The output register holds a character until it is taken, so a stalled
//   receiver freezes the sequencer; the final character may wait while the
//   next reading is accepted. Reset empties it and returns to idle.
`include "assert_macros.svh"

module signed_decimal_report_formatter #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Slave side: tdata = reading[31:0]
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [sdrf_pkg::IN_W-1:0]   i_s_axis_tdata,
    // Master side: tdata = out_char[7:0]; tlast = last_char
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [sdrf_pkg::CHAR_W-1:0] o_m_axis_tdata,
    output logic                        o_m_axis_tlast
);
    import sdrf_pkg::*;

    // Decimal digits that a VALUE_BITS-bit magnitude can need.
    localparam int unsigned DIGITS    = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int unsigned BCD_W     = DIGITS * 4;
    localparam int unsigned BIT_CNT_W = $clog2(VALUE_BITS);
    localparam int unsigned DIG_CNT_W = $clog2(DIGITS + 1);

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic                  r_neg, n_neg;
    logic [BIT_CNT_W-1:0]  r_bit_cnt, n_bit_cnt;
    logic [DIG_CNT_W-1:0]  r_dig_left, n_dig_left;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;

    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_neg;
    logic                  w_slot;
    logic [3:0]            w_top;
    logic [BCD_W-1:0]      w_adj;

    // Add three to every BCD digit of five or more before the next shift.
    function automatic logic [BCD_W-1:0] f_adjust(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] res;
        logic [3:0]       nib;
        res = v;
        for (int i = 0; i < DIGITS; i++) begin
            nib = v[4*i +: 4];
            res[4*i +: 4] = (nib >= BCD_LIMIT) ? (nib + BCD_ADJ) : nib;
        end
        return res;
    endfunction

    // Take the low VALUE_BITS bits of the reading, zero-extending if wider.
    generate
        if (VALUE_BITS <= IN_W) begin : g_narrow
            assign w_raw = i_s_axis_tdata[VALUE_BITS-1:0];
        end else begin : g_wide
            assign w_raw = {{(VALUE_BITS - IN_W){1'b0}}, i_s_axis_tdata};
        end
    endgenerate

    // Sign and magnitude; the most negative value stays correct as unsigned.
    assign w_neg = w_raw[VALUE_BITS-1];
    assign w_mag = w_neg ? (VALUE_BITS'(0) - w_raw) : w_raw;

    // The output register can take a new character this cycle.
    assign w_slot = !r_out_valid || i_m_axis_tready;
    assign w_top  = r_bcd[BCD_W-1 -: 4];
    assign w_adj  = f_adjust(r_bcd);

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (r_bit_cnt == '0) begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                if (!(w_top == 4'd0 && r_dig_left > DIG_CNT_W'(1))) begin
                    n_state = S_EMIT_R;
                end
            end
            S_EMIT_R: begin
                if (w_slot) begin
                    n_state = S_EMIT_SP;
                end
            end
            S_EMIT_SP: begin
                if (w_slot) begin
                    n_state = r_neg ? S_EMIT_MINUS : S_EMIT_DIG;
                end
            end
            S_EMIT_MINUS: begin
                if (w_slot) begin
                    n_state = S_EMIT_DIG;
                end
            end
            S_EMIT_DIG: begin
                if (w_slot && r_dig_left == DIG_CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_bit_cnt   = r_bit_cnt;
        n_dig_left  = r_dig_left;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_bin     = w_mag;
                    n_neg     = w_neg;
                    n_bcd     = '0;
                    n_bit_cnt = BIT_CNT_W'(VALUE_BITS - 1);
                end
            end
            S_CONV: begin
                // One bit of the magnitude moves into the BCD register.
                n_bcd     = {w_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                n_bin     = r_bin << 1;
                n_bit_cnt = r_bit_cnt - 1'b1;
                if (r_bit_cnt == '0) begin
                    n_dig_left = DIG_CNT_W'(DIGITS);
                end
            end
            S_TRIM: begin
                // Drop a leading zero digit, keeping at least one digit.
                if (w_top == 4'd0 && r_dig_left > DIG_CNT_W'(1)) begin
                    n_bcd      = r_bcd << 4;
                    n_dig_left = r_dig_left - 1'b1;
                end
            end
            S_EMIT_R: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_R;
                    n_out_last  = 1'b0;
                end
            end
            S_EMIT_SP: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_SPACE;
                    n_out_last  = 1'b0;
                end
            end
            S_EMIT_MINUS: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_MINUS;
                    n_out_last  = 1'b0;
                end
            end
            S_EMIT_DIG: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_ZERO + {4'd0, w_top};
                    n_out_last  = (r_dig_left == DIG_CNT_W'(1));
                    n_bcd       = r_bcd << 4;
                    n_dig_left  = r_dig_left - 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_m_axis_tready;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_neg      <= n_neg;
        r_bit_cnt  <= n_bit_cnt;
        r_dig_left <= n_dig_left;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;

    // Checks on the sequencer and the digit datapath.
    `ASSERT_NEXT(a_accept_starts_conv, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_state == S_CONV, "accepted item did not start conversion")
    `ASSERT_SAME(a_trim_has_digits, i_clk, i_rst_n, r_state == S_TRIM, r_dig_left != '0, "trim with no digits left")
    `ASSERT_SAME(a_emit_digit_valid, i_clk, i_rst_n, r_state == S_EMIT_DIG, (r_dig_left != '0) && (w_top <= 4'd9), "bad digit at emission")
    `ASSERT_NEXT(a_last_returns_idle, i_clk, i_rst_n, r_state == S_EMIT_DIG && w_slot && r_dig_left == DIG_CNT_W'(1), r_state == S_IDLE && o_m_axis_tvalid && o_m_axis_tlast, "final character did not end the report")

endmodule
